### design/priority_counting_semaphore_defines.svh
// Assertion macros used by the semaphore top module.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PRIORITY_COUNTING_SEMAPHORE_DEFINES_SVH
`define PRIORITY_COUNTING_SEMAPHORE_DEFINES_SVH

// same-cycle implication
`define PSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/psc_pkg.sv
// Shared types and constants for the priority counting semaphore.
// No dependencies.
package psc_pkg;

    localparam int ID_W    = 6;
    localparam int PRIO_W  = 6;
    localparam int COUNT_W = 8;
    localparam int STAT_W  = 3;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_GRANTED  = 3'd0;
    localparam t_status ST_QUEUED   = 3'd1;
    localparam t_status ST_RELEASED = 3'd2;
    localparam t_status ST_WOKE     = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic FUNC_DOWN = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_waiter;

    // table operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

### design/priority_counting_semaphore.sv
// Priority counting semaphore: count register plus a row of sorted waiter cells.
// Result strobe o_valid is registered and rises in the cycle after start; throughput one item per cycle,
// set by the parallel shift of the cell row. o_busy stays low.
// Synchronous active-low reset clears count, waiter total and the result strobe;
// the initial_count write loads the count and empties the table.
// The receiver cannot stall results.
`include "priority_counting_semaphore_defines.svh"
module priority_counting_semaphore
    import psc_pkg::*;
#(
    parameter  int MAX_WAITERS = 16,
    localparam int CNT_W       = $clog2(MAX_WAITERS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [COUNT_W-1:0]  i_cfg_wr_data,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_func,
    input  logic [ID_W-1:0]     i_requester_id,
    input  logic [PRIO_W-1:0]   i_requester_priority,
    output logic                o_valid,
    output logic [STAT_W-1:0]   o_status,
    output logic [ID_W-1:0]     o_woken_id,
    output logic [PRIO_W-1:0]   o_woken_priority,
    output logic [COUNT_W-1:0]  o_count_after,
    output logic [CNT_W-1:0]    o_waiters_after
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WAITERS);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   n_total;
    logic               r_valid;
    t_status            r_status;
    t_status            n_status;
    logic [ID_W-1:0]    r_woken_id;
    logic [PRIO_W-1:0]  r_woken_prio;
    logic [COUNT_W-1:0] r_count_out;
    logic [CNT_W-1:0]   r_total_out;

    t_cell_ctl          w_ctl;
    t_waiter            w_new;
    t_waiter            w_entry [MAX_WAITERS];
    logic               w_after [MAX_WAITERS];
    logic               w_accept;
    logic               w_woke;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_new    = '{id: i_requester_id, prio: i_requester_priority};
    assign w_woke   = (r_total != '0);

    always_comb begin
        n_count  = r_count;
        n_total  = r_total;
        n_status = ST_RELEASED;
        w_ctl    = '0;
        if (i_func == FUNC_DOWN) begin
            priority if (r_count != '0) begin
                n_count  = r_count - 1'b1;
                n_status = ST_GRANTED;
            end else if (r_total < MAX_CNT) begin
                n_total   = r_total + 1'b1;
                n_status  = ST_QUEUED;
                w_ctl.ins = w_accept;
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            if (w_woke) begin
                n_total   = r_total - 1'b1;
                n_status  = ST_WOKE;
                w_ctl.pop = w_accept;
            end
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_WAITERS; k++) begin : g_cell
            logic    w_left_after;
            t_waiter w_left;
            t_waiter w_right;
            if (k == 0) begin : g_head
                assign w_left_after = 1'b1;
                assign w_left       = w_new;
            end else begin : g_body
                assign w_left_after = w_after[k-1];
                assign w_left       = w_entry[k-1];
            end
            if (k == MAX_WAITERS - 1) begin : g_tail
                assign w_right = w_entry[k];
            end else begin : g_mid
                assign w_right = w_entry[k+1];
            end
            psc_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occ        (CNT_W'(k) < r_total),
                .i_left_after (w_left_after),
                .i_left       (w_left),
                .i_right      (w_right),
                .i_new        (w_new),
                .o_entry      (w_entry[k]),
                .o_after      (w_after[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
                r_total <= '0;
            end else if (w_accept) begin
                r_count <= n_count;
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_woken_id   <= (n_status == ST_WOKE) ? w_entry[0].id : '0;
            r_woken_prio <= (n_status == ST_WOKE) ? w_entry[0].prio : '0;
            r_count_out  <= n_count;
            r_total_out  <= n_total;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_woken_id       = r_woken_id;
    assign o_woken_priority = r_woken_prio;
    assign o_count_after    = r_count_out;
    assign o_waiters_after  = r_total_out;

    `PSC_ASSERT_NOW(a_total_bound, 1'b1, r_total <= MAX_CNT, "waiter total above table size")
    `PSC_ASSERT_NEXT(a_result_follows, w_accept, o_valid, "accepted item gave no result")
    `PSC_ASSERT_NOW(a_full_total, o_valid && (o_status == ST_FULL), o_waiters_after == MAX_CNT, "rejected with table not full")
    `PSC_ASSERT_NOW(a_queued_zero, o_valid && (o_status == ST_QUEUED), o_count_after == '0, "queued with nonzero count")

endmodule

### design/psc_cell.sv
// One slot of the sorted waiter table.
// Depends on psc_pkg; shifts toward the front on pop, toward the back on insert.
module psc_cell
    import psc_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  logic      i_left_after,
    input  t_waiter   i_left,
    input  t_waiter   i_right,
    input  t_waiter   i_new,
    output t_waiter   o_entry,
    output logic      o_after
);

    t_waiter r_entry;
    t_waiter n_entry;

    // new item lands behind every occupied slot of equal or higher priority
    assign o_after = i_occ && (r_entry.prio >= i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        priority if (i_ctl.ins && !o_after) begin
            n_entry = i_left_after ? i_new : i_left;
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
